### hw/rtl/assert_macros.svh
// assertion helpers shared by the deframer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// general property checked on every rising clock edge outside reset
`define ASSERT_CHK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication checked outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### hw/rtl/ifd_pkg.sv
package ifd_pkg;

   localparam int unsigned RX_W    = 8;
   localparam int unsigned LEN_W   = 16;
   localparam int unsigned CSR_IDX_W = 3;

   // bytes in a frame besides the payload, counted from the direction byte
   localparam logic [LEN_W-1:0] OVERHEAD = 16'd6;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_MARK  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_MARK = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_MARK    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_END_MARK    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LEN_LIMIT   = 3'd4;

   // register reset values
   localparam logic [RX_W-1:0]  FIRST_MARK_RST  = 8'd70;
   localparam logic [RX_W-1:0]  SECOND_MARK_RST = 8'd185;
   localparam logic [RX_W-1:0]  DIR_MARK_RST    = 8'd104;
   localparam logic [RX_W-1:0]  END_MARK_RST    = 8'd22;
   localparam logic [LEN_W-1:0] LEN_LIMIT_RST   = 16'd1024;

   typedef enum logic [2:0] {
      ST_VALID      = 3'd0,
      ST_BAD_FIRST  = 3'd1,
      ST_BAD_SECOND = 3'd2,
      ST_BAD_DIR    = 3'd3,
      ST_BAD_LEN    = 3'd4,
      ST_BAD_END    = 3'd5,
      ST_BAD_SUM    = 3'd6
   } status_type;

   typedef struct packed {
      logic [RX_W-1:0]  first_mark;
      logic [RX_W-1:0]  second_mark;
      logic [RX_W-1:0]  dir_mark;
      logic [RX_W-1:0]  end_mark;
      logic [LEN_W-1:0] len_limit;
   } cfg_type;

   typedef struct packed {
      logic             valid;
      logic             is_status;
      logic [RX_W-1:0]  payload_byte;
      status_type       status_code;
      logic [LEN_W-1:0] payload_count;
      logic [LEN_W-1:0] sum_value;
   } result_type;

endpackage

### hw/rtl/ifd_parser.sv
`include "assert_macros.svh"

module ifd_parser import ifd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic [RX_W-1:0] rx_byte,
   input  cfg_type         cfg,
   output result_type      res
);

   typedef enum logic [2:0] {
      PH_HUNT, PH_SECOND, PH_DIR, PH_LEN_HI, PH_LEN_LO, PH_BODY, PH_END
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [RX_W-1:0]  len_hi_ff, len_hi_in;
   logic [LEN_W-1:0] count_ff, count_in;
   logic [LEN_W-1:0] seen_ff, seen_in;
   logic [LEN_W-1:0] sum_ff, sum_in;
   logic [LEN_W-1:0] rsum_ff, rsum_in;

   logic [LEN_W-1:0] frame_len;
   logic [LEN_W-1:0] sum_add;

   assign frame_len = {len_hi_ff, rx_byte};
   assign sum_add   = sum_ff + {{(LEN_W-RX_W){1'b0}}, rx_byte};

   always_comb begin
      phase_in  = phase_ff;
      len_hi_in = len_hi_ff;
      count_in  = count_ff;
      seen_in   = seen_ff;
      sum_in    = sum_ff;
      rsum_in   = rsum_ff;
      res       = '0;
      case (phase_ff)
         PH_SECOND: begin
            if (rx_byte != cfg.second_mark) begin
               res.valid       = 1'b1;
               res.is_status   = 1'b1;
               res.status_code = ST_BAD_SECOND;
               phase_in        = PH_HUNT;
            end else begin
               phase_in = PH_DIR;
            end
         end
         PH_DIR: begin
            if (rx_byte != cfg.dir_mark) begin
               res.valid       = 1'b1;
               res.is_status   = 1'b1;
               res.status_code = ST_BAD_DIR;
               phase_in        = PH_HUNT;
            end else begin
               sum_in   = {{(LEN_W-RX_W){1'b0}}, rx_byte};
               phase_in = PH_LEN_HI;
            end
         end
         PH_LEN_HI: begin
            sum_in    = sum_add;
            len_hi_in = rx_byte;
            phase_in  = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            sum_in = sum_add;
            if (frame_len >= cfg.len_limit || frame_len < OVERHEAD) begin
               res.valid       = 1'b1;
               res.is_status   = 1'b1;
               res.status_code = ST_BAD_LEN;
               res.sum_value   = sum_add;
               phase_in        = PH_HUNT;
            end else begin
               seen_in  = '0;
               count_in = frame_len - OVERHEAD;
               phase_in = PH_BODY;
            end
         end
         PH_BODY: begin
            if (seen_ff < count_ff) begin
               // payload byte passes straight out
               seen_in          = seen_ff + 16'd1;
               sum_in           = sum_add;
               res.valid        = 1'b1;
               res.payload_byte = rx_byte;
            end else if (seen_ff == count_ff) begin
               rsum_in = {rx_byte, {RX_W{1'b0}}};
               seen_in = seen_ff + 16'd1;
            end else begin
               rsum_in  = {rsum_ff[LEN_W-1:RX_W], rx_byte};
               phase_in = PH_END;
            end
         end
         PH_END: begin
            res.valid         = 1'b1;
            res.is_status     = 1'b1;
            res.payload_count = count_ff;
            res.sum_value     = sum_ff;
            // end mark is checked ahead of the checksum
            if (rx_byte != cfg.end_mark) begin
               res.status_code = ST_BAD_END;
            end else if (rsum_ff != sum_ff) begin
               res.status_code = ST_BAD_SUM;
            end else begin
               res.status_code = ST_VALID;
            end
            phase_in = PH_HUNT;
         end
         default: begin
            if (rx_byte != cfg.first_mark) begin
               res.valid       = 1'b1;
               res.is_status   = 1'b1;
               res.status_code = ST_BAD_FIRST;
               phase_in        = PH_HUNT;
            end else begin
               phase_in = PH_SECOND;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
      end else if (step) begin
         phase_ff  <= phase_in;
         len_hi_ff <= len_hi_in;
         count_ff  <= count_in;
         seen_ff   <= seen_in;
         sum_ff    <= sum_in;
         rsum_ff   <= rsum_in;
      end
   end

   `ASSERT_CHK(a_status_rehunts, clock, reset, step && res.valid && res.is_status |=> phase_ff == PH_HUNT, "status did not return to hunting")
   `ASSERT_IMPL(a_seen_bounded, clock, reset, phase_ff == PH_BODY, ({1'b0, seen_ff} <= ({1'b0, count_ff} + 17'd1)), "body byte counter overran payload plus checksum")

endmodule

### hw/rtl/isp_frame_deframer_core.sv
// byte-serial deframer for marker / length / sum16 frames
// req channel: one received byte per transfer in req_tdata
// rsp channel: payload bytes as they arrive (rsp_tuser low) and one status
//   transfer per frame or per failure (rsp_tuser high)
// csr channel: register writes, index 0..4 = first mark, second mark,
//   direction mark, end mark, length limit; other indexes are ignored;
//   always ready, write only while the stream is idle
// output: a result is registered and appears on rsp in the cycle after its byte is taken
// throughput: one byte per cycle while rsp is not stalled; the frame state
//   update is the only loop
// reset: synchronous; returns to hunting for the first mark, restores the
//   register defaults and empties the output register
// stall: the output register holds its transfer while rsp_tready is low;
//   req_tready drops only while that register is full and not drained, so
//   a byte is still taken in the cycle the held result leaves
`include "assert_macros.svh"

module isp_frame_deframer_core import ifd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // input byte stream
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] rx_byte
   // result stream
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [47:0]          rsp_tdata,   // [7:0] payload_byte, [10:8] status_code,
                                             // [26:11] payload_count, [42:27] sum_value,
                                             // [47:43] zero
   output logic                 rsp_tuser,   // [0] is_status
   // register writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LEN_W-1:0]     csr_data
);

   cfg_type    cfg_ff;
   result_type step_res;
   logic       step;

   logic             rsp_valid_ff;
   logic             is_status_ff;
   logic [RX_W-1:0]  payload_byte_ff;
   status_type       status_code_ff;
   logic [LEN_W-1:0] payload_count_ff;
   logic [LEN_W-1:0] sum_value_ff;

   // register file, writes always accepted
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_mark  <= FIRST_MARK_RST;
         cfg_ff.second_mark <= SECOND_MARK_RST;
         cfg_ff.dir_mark    <= DIR_MARK_RST;
         cfg_ff.end_mark    <= END_MARK_RST;
         cfg_ff.len_limit   <= LEN_LIMIT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FIRST_MARK:  cfg_ff.first_mark  <= csr_data[RX_W-1:0];
            CSR_SECOND_MARK: cfg_ff.second_mark <= csr_data[RX_W-1:0];
            CSR_DIR_MARK:    cfg_ff.dir_mark    <= csr_data[RX_W-1:0];
            CSR_END_MARK:    cfg_ff.end_mark    <= csr_data[RX_W-1:0];
            CSR_LEN_LIMIT:   cfg_ff.len_limit   <= csr_data;
            default: ;
         endcase
      end
   end

   // take a byte whenever the output register is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;

   ifd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (req_tdata),
      .cfg     (cfg_ff),
      .res     (step_res)
   );

   // output register: valid flag under reset, payload only loaded
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_tready) begin
         rsp_valid_ff <= step && step_res.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (step && step_res.valid) begin
         is_status_ff     <= step_res.is_status;
         payload_byte_ff  <= step_res.payload_byte;
         status_code_ff   <= step_res.status_code;
         payload_count_ff <= step_res.payload_count;
         sum_value_ff     <= step_res.sum_value;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = is_status_ff;
   assign rsp_tdata  = {5'b0, sum_value_ff, payload_count_ff, status_code_ff,
                        payload_byte_ff};

   `ASSERT_IMPL(a_ready_only_on_stall, clock, reset, !req_tready, rsp_valid_ff && !rsp_tready, "input blocked without a stalled result")
   `ASSERT_IMPL(a_payload_fields_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata[42:8] == 35'd0, "payload transfer carries status fields")
   `ASSERT_CHK(a_taken_on_drain, clock, reset, rsp_valid_ff && rsp_tready && !(req_tvalid && step_res.valid) |=> !rsp_valid_ff, "drained result was not released")

endmodule
